[hw/rtl/vdib_pkg.sv]
// ----------------------------------------------------------------------------
// vdib_pkg - shared types for the vertex dedup index builder
// Vertex word, chain token, controller states and lookup status codes.
// ----------------------------------------------------------------------------
package vdib_pkg;

    localparam int VERTEX_W = 384;   // twelve 32-bit words

    typedef logic [VERTEX_W-1:0] vertex_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic valid;
        logic found;
    } token_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    localparam logic [1:0] STATUS_FOUND = 2'd0;
    localparam logic [1:0] STATUS_ADDED = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

[hw/rtl/vdib_cell.sv]
// ----------------------------------------------------------------------------
// vdib_cell - one table entry of the dedup chain
// Holds one unique vertex, compares it with the broadcast query as the token
// passes, and stores the query when it is the next free entry.
// ----------------------------------------------------------------------------
module vdib_cell
    import vdib_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int IDXW     = 8,
    parameter int CNTW     = 9
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  vertex_t         query,
    input  logic [CNTW-1:0] count,
    input  token_t          tok_in,
    input  logic [IDXW-1:0] idx_in,
    output token_t          tok_out,
    output logic [IDXW-1:0] idx_out
);

    localparam logic [CNTW-1:0] MY_CNT = CNTW'(CELL_IDX);
    localparam logic [IDXW-1:0] MY_IDX = IDXW'(CELL_IDX);

    vertex_t         entry_reg;
    token_t          tok_reg;
    token_t          tok_next;
    logic [IDXW-1:0] idx_reg;
    logic [IDXW-1:0] idx_next;
    logic            hit;
    logic            store;

    // entries at or above count were never written for this mesh
    assign hit   = tok_in.valid && !tok_in.found && (MY_CNT < count) && (entry_reg == query);
    assign store = tok_in.valid && !tok_in.found && (count == MY_CNT);

    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.found = tok_in.found || hit;
        idx_next       = hit ? MY_IDX : idx_in;
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            entry_reg <= query;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

[hw/rtl/vertex_dedup_index_builder_core.sv]
// ----------------------------------------------------------------------------
// vertex_dedup_index_builder_core - unique vertex table with index lookup
// A row of entry cells; a search token walks the row once per vertex.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  vtx     | in        | vtx_valid/vtx_stall  | first_of_mesh, 12 vertex words
//  res     | out       | res_valid/res_stall  | vertex_index, lookup_status
//
//  Flow: the token walks the row one cell per cycle; the outcome is latched
//  as the state moves to DONE, DONE loads the result register once it is
//  free, and the core goes back to IDLE to take the next vertex; no new
//  vertex is taken before the last one has left DONE.
//  Reset: the unique count clears; entry contents are left as they are and
//  are only ever compared below the count.
//  Stalls: the result register parts the two sides, so a new vertex is taken
//  while an earlier result still waits; a finished search holds in DONE
//  until the result register is free.
//
module vertex_dedup_index_builder_core
    import vdib_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    // vertex in
    input  logic        vtx_valid,
    output logic        vtx_stall,
    input  logic        first_of_mesh,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] norm_x,
    input  logic [31:0] norm_y,
    input  logic [31:0] norm_z,
    input  logic [31:0] color_r,
    input  logic [31:0] color_g,
    input  logic [31:0] color_b,
    input  logic [31:0] color_a,
    input  logic [63:0] tex_uv,
    // result out
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  vertex_index,
    output logic [1:0]  lookup_status
);

    localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(TABLE_DEPTH);

    state_t          state_reg;
    state_t          state_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            start_reg;
    logic            start_next;
    vertex_t         query_reg;

    logic [CNTW-1:0] pend_idx_reg;
    logic [CNTW-1:0] pend_idx_next;
    logic [1:0]      pend_status_reg;
    logic [1:0]      pend_status_next;

    logic            res_valid_reg;
    logic            res_valid_next;
    logic [7:0]      res_idx_reg;
    logic [7:0]      res_idx_next;
    logic [1:0]      res_status_reg;
    logic [1:0]      res_status_next;

    logic            vtx_take;
    logic            res_free;
    logic [CNTW+7:0] pend_idx_wide;

    token_t          tok   [0:TABLE_DEPTH];
    logic [IDXW-1:0] idx_c [0:TABLE_DEPTH];
    token_t          tok_end;
    logic [IDXW-1:0] idx_end;

    assign vtx_stall = (state_reg != ST_IDLE);
    assign vtx_take  = vtx_valid && !vtx_stall;
    assign res_free  = !res_valid_reg || !res_stall;

    // the query sits in one register and is broadcast to every cell
    always_ff @(posedge clk)
    begin
        if (vtx_take)
        begin
            query_reg <= {pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                          color_r, color_g, color_b, color_a, tex_uv};
        end
    end

    // ---- row of entry cells -------------------------------------------------
    assign tok[0].valid = start_reg;
    assign tok[0].found = 1'b0;
    assign idx_c[0]     = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        vdib_cell #(
            .CELL_IDX (i),
            .IDXW     (IDXW),
            .CNTW     (CNTW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .query   (query_reg),
            .count   (count_reg),
            .tok_in  (tok[i]),
            .idx_in  (idx_c[i]),
            .tok_out (tok[i+1]),
            .idx_out (idx_c[i+1])
        );
    end

    assign tok_end = tok[TABLE_DEPTH];
    assign idx_end = idx_c[TABLE_DEPTH];

    // vertex_index carries the low 8 bits of the index
    assign pend_idx_wide = {8'd0, pend_idx_reg};

    // ---- controller ----------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        start_next       = 1'b0;
        pend_idx_next    = pend_idx_reg;
        pend_status_next = pend_status_reg;
        res_valid_next   = res_valid_reg && res_stall;
        res_idx_next     = res_idx_reg;
        res_status_next  = res_status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (vtx_take)
                begin
                    start_next = 1'b1;
                    state_next = ST_SEARCH;
                    if (first_of_mesh)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (tok_end.valid)
                begin
                    state_next = ST_DONE;
                    if (tok_end.found)
                    begin
                        pend_idx_next    = CNTW'(idx_end);
                        pend_status_next = STATUS_FOUND;
                    end
                    else if (count_reg < DEPTH_CNT)
                    begin
                        // the cell at index count took the vertex
                        pend_idx_next    = count_reg;
                        pend_status_next = STATUS_ADDED;
                        count_next       = count_reg + 1'b1;
                    end
                    else
                    begin
                        pend_idx_next    = '0;
                        pend_status_next = STATUS_FULL;
                    end
                end
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_idx_next    = pend_idx_wide[7:0];
                    res_status_next = pend_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            start_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg    <= pend_idx_next;
        pend_status_reg <= pend_status_next;
        res_idx_reg     <= res_idx_next;
        res_status_reg  <= res_status_next;
    end

    assign res_valid     = res_valid_reg;
    assign vertex_index  = res_idx_reg;
    assign lookup_status = res_status_reg;

    // ---- checks --------------------------------------------------------------
    a_tok_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tok_end.valid |-> state_reg == ST_SEARCH)
        else $error("search token left the row outside a search");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("unique count above table depth");

    a_start_follows_take: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_take |=> start_reg && state_reg == ST_SEARCH)
        else $error("accepted vertex did not start a search");

    a_add_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && tok_end.valid && !tok_end.found
         && count_reg < DEPTH_CNT)
        |=> count_reg == $past(count_reg) + 1'b1 && pend_status_reg == STATUS_ADDED)
        else $error("new vertex stored without count increment");

endmodule

[sim/vertex_dedup_index_builder_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_dedup_index_builder_core_tb - self-checking bench for the dedup core
// Streams mesh vertices through the core and checks each index and status
// against a predicted unique-vertex table.
// ----------------------------------------------------------------------------
module vertex_dedup_index_builder_core_tb
    import vdib_pkg::*;
();

    localparam int TABLE_DEPTH     = 256;
    // one search walks the whole row of cells, so this covers any
    // result still in flight after the last one we were waiting for
    localparam int SETTLE_CYCLES   = TABLE_DEPTH + 16;
    // long enough for several searches to finish behind a blocked output
    localparam int HOLD_OFF_CYCLES = 2000;

    // float32 patterns that deserve extra weight in the compare
    localparam logic [31:0] F32_POS_ZERO = 32'h0000_0000;
    localparam logic [31:0] F32_NEG_ZERO = 32'h8000_0000;
    localparam logic [31:0] F32_QNAN     = 32'h7fc0_0000;
    localparam logic [31:0] F32_ONE      = 32'h3f80_0000;

    typedef struct packed {
        logic [7:0] slot;
        logic [1:0] status;
    } lookup_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        vtx_valid;
    logic        vtx_stall;
    logic        first_of_mesh;
    logic [31:0] pos_x, pos_y, pos_z;
    logic [31:0] norm_x, norm_y, norm_z;
    logic [31:0] color_r, color_g, color_b, color_a;
    logic [63:0] tex_uv;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [7:0]  vertex_index;
    logic [1:0]  lookup_status;

    // predicted unique-vertex table, mirrors what the core should hold
    vertex_t     mesh_table [TABLE_DEPTH];
    int unsigned mesh_count = 0;

    lookup_t     expected_lookups [$];

    int failures       = 0;
    int vertices_taken = 0;
    int found_checked  = 0;
    int added_checked  = 0;
    int full_checked   = 0;

    // idling controls; no_idle is shared by both sides
    bit no_idle    = 1'b0;
    int stall_left = 0;   // short stall before the pending result
    int hold_left  = 0;   // long output hold-off, counted down below

    vertex_dedup_index_builder_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: bitwise compare against entries below the count, first hit
    // wins; otherwise append, or report full when no room is left.
    // ------------------------------------------------------------------------
    function automatic lookup_t predict_lookup(input logic first, input vertex_t v);
        lookup_t r;
        logic    hit;
        hit      = 1'b0;
        r.slot   = '0;
        r.status = STATUS_FULL;
        if (first)
            mesh_count = 0;
        for (int e = 0; e < mesh_count && !hit; e++)
        begin
            if (mesh_table[e] == v)
            begin
                hit      = 1'b1;
                r.slot   = 8'(e);
                r.status = STATUS_FOUND;
            end
        end
        if (!hit && mesh_count < TABLE_DEPTH)
        begin
            mesh_table[mesh_count] = v;
            r.slot                 = 8'(mesh_count);
            r.status               = STATUS_ADDED;
            mesh_count++;
        end
        return r;
    endfunction

    // input side: every accepted item gets its expectation at the same edge
    always @(posedge clk)
    begin
        lookup_t predicted;
        if (rst_n && vtx_valid && !vtx_stall)
        begin
            predicted = predict_lookup(first_of_mesh,
                {pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                 color_r, color_g, color_b, color_a, tex_uv});
            expected_lookups = {expected_lookups, predicted};
            vertices_taken++;
        end
    end

    // output side: compare against the oldest expectation, then draw the
    // stall to put in front of the next result
    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_lookups.size() == 0)
            begin
                $error("unexpected result: vertex_index %0d lookup_status %0d",
                       vertex_index, lookup_status);
                failures++;
            end
            else
            begin
                want = expected_lookups.pop_front();
                if (vertex_index !== want.slot)
                begin
                    $error("vertex_index: expected %0d, got %0d", want.slot, vertex_index);
                    failures++;
                end
                if (lookup_status !== want.status)
                begin
                    $error("lookup_status: expected %0d, got %0d",
                           want.status, lookup_status);
                    failures++;
                end
                case (want.status)
                    STATUS_FOUND: found_checked++;
                    STATUS_ADDED: added_checked++;
                    default:      full_checked++;
                endcase
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 4);
        end
    end

    // receiver stall, one assignment per falling edge; the long hold-off
    // overrides everything while it runs
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else if (res_valid && stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else
            res_stall <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sender: random gap, present the item on the falling edge, hold it until
    // it is taken. Valid stays high on return so back-to-back items never
    // drop it.
    // ------------------------------------------------------------------------
    task automatic send_vertex(input logic first, input vertex_t v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        repeat (gap)
        begin
            @(negedge clk);
            vtx_valid <= 1'b0;
        end
        @(negedge clk);
        vtx_valid     <= 1'b1;
        first_of_mesh <= first;
        {pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
         color_r, color_g, color_b, color_a, tex_uv} <= v;
        @(posedge clk);
        while (vtx_stall)
            @(posedge clk);
    endtask

    // sender pauses until the core has handed back everything
    task automatic wait_for_results();
        @(negedge clk);
        vtx_valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
    endtask

    // twelve words, each now and then a signed zero, a NaN or all ones
    function automatic vertex_t random_vertex();
        vertex_t     v;
        logic [31:0] w;
        v = '0;
        for (int k = 0; k < 12; k++)
        begin
            case ($urandom_range(0, 9))
                0:       w = F32_POS_ZERO;
                1:       w = F32_NEG_ZERO;
                2:       w = F32_QNAN;
                3:       w = '1;
                default: w = $urandom;
            endcase
            v = {v[VERTEX_W-33:0], w};
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Directed: field extremes, signed zeros, NaN equality, single-bit
    // differences, clear-and-store, and a non-zero value in each word alone
    // ------------------------------------------------------------------------
    task automatic test_directed();
        vertex_t zero_v, ones_v, nzero_v, nan_v;
        zero_v  = '0;
        ones_v  = '1;
        nzero_v = {F32_NEG_ZERO, {(VERTEX_W-32){1'b0}}};
        nan_v   = {12{F32_QNAN}};
        send_vertex(1'b1, zero_v);
        send_vertex(1'b0, ones_v);
        send_vertex(1'b0, zero_v);                      // found at 0
        send_vertex(1'b0, nzero_v);                     // -0 is not +0
        send_vertex(1'b0, nan_v);
        send_vertex(1'b0, nan_v);                       // same NaN bits match
        send_vertex(1'b0, zero_v ^ vertex_t'(1));       // tex v lsb only
        send_vertex(1'b0, zero_v ^ (vertex_t'(1) << 63)); // tex u msb only
        send_vertex(1'b0, ones_v);
        send_vertex(1'b1, ones_v);                      // clear, lands at 0
        send_vertex(1'b0, zero_v);                      // old entries gone
        send_vertex(1'b0, ones_v);
        for (int k = 0; k < 12; k++)
            send_vertex(1'b0, vertex_t'(F32_ONE) << (32 * k));
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Table full: fill every entry, then new vertices are refused while
    // stored ones are still found, first and last entry included
    // ------------------------------------------------------------------------
    task automatic test_table_full();
        vertex_t stored [TABLE_DEPTH];
        vertex_t v;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            v = random_vertex();
            v[VERTEX_W-1 -: 32] = 32'(i);               // keeps entries distinct
            stored[i] = v;
            send_vertex(i == 0, v);
        end
        for (int i = 0; i < 4; i++)
            send_vertex(1'b0, random_vertex() | (vertex_t'(1) << (VERTEX_W-1)));
        send_vertex(1'b0, stored[0]);
        send_vertex(1'b0, stored[TABLE_DEPTH-1]);
        send_vertex(1'b0, stored[$urandom_range(1, TABLE_DEPTH-2)]);
        send_vertex(1'b0, ~stored[0]);
        send_vertex(1'b1, stored[TABLE_DEPTH-1]);       // clear frees the table
        send_vertex(1'b0, stored[0]);
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Random meshes: a share drawn per mesh is fresh; of the rest, three in
    // four repeat a mesh vertex, the fourth is a one-bit near miss. The odd mid-mesh
    // clear is noise; now and then a long fresh mesh hits the full table.
    // ------------------------------------------------------------------------
    task automatic test_random_meshes(input int n_items);
        vertex_t pool [$];
        vertex_t v;
        int      left_in_mesh;
        int      fresh_pct;
        int      pick;
        logic    first;
        left_in_mesh = 0;
        fresh_pct    = 30;
        for (int n = 0; n < n_items; n++)
        begin
            if (left_in_mesh == 0)
            begin
                pool.delete();
                first = 1'b1;
                if ($urandom_range(0, 11) == 0)
                begin
                    left_in_mesh = $urandom_range(TABLE_DEPTH + 4, TABLE_DEPTH + 40);
                    fresh_pct    = 97;
                end
                else
                begin
                    left_in_mesh = $urandom_range(1, 80);
                    fresh_pct    = $urandom_range(10, 70);
                end
            end
            else
                first = ($urandom_range(0, 49) == 0);
            left_in_mesh--;
            pick = $urandom_range(0, 99);
            if (pool.size() == 0 || pick < fresh_pct)
            begin
                v = random_vertex();
                pool = {pool, v};
            end
            else if (pick < fresh_pct + (100 - fresh_pct) * 3 / 4)
                v = pool[$urandom_range(0, pool.size() - 1)];
            else
            begin
                v = pool[$urandom_range(0, pool.size() - 1)]
                    ^ (vertex_t'(1) << $urandom_range(0, VERTEX_W - 1));
                pool = {pool, v};
            end
            send_vertex(first, v);
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Back-pressure: output blocked for a long stretch while the sender keeps
    // offering, so the result register and the finished search both fill and
    // the input stalls
    // ------------------------------------------------------------------------
    task automatic test_output_hold_off();
        vertex_t v;
        hold_left = HOLD_OFF_CYCLES;
        v = random_vertex();
        send_vertex(1'b1, v);
        for (int i = 0; i < 11; i++)
            send_vertex(1'b0, ($urandom_range(0, 2) == 0) ? v : random_vertex());
        wait_for_results();
    endtask

    // back-to-back items with the output always free
    task automatic test_full_rate();
        no_idle = 1'b1;
        test_random_meshes(40);
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        vtx_valid     = 1'b0;
        first_of_mesh = 1'b0;
        {pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
         color_r, color_g, color_b, color_a, tex_uv} = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_table_full();
        test_output_hold_off();
        test_full_rate();
        test_random_meshes(560);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d vertices in; results checked: %0d found, %0d added, %0d table full",
                 vertices_taken, found_checked, added_checked, full_checked);
        $display("covered signed zeros, NaN matches, one-bit misses, mid-mesh clears, %s",
                 "full-table refusals and output hold-off");
        if (failures == 0)
            $display("vertex_dedup_index_builder_core regression: pass");
        else
            $display("vertex_dedup_index_builder_core regression: fail");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #50_000_000;
        $display("vertex_dedup_index_builder_core regression: fail");
        $finish;
    end

endmodule
